FILE: hdl/odm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package odm_pkg;

  localparam int THRESHOLD_W = 13;
  localparam int HOLD_W      = 24;
  localparam int DIVIDER_W   = 8;
  localparam int CONFIRM_W   = 4;
  localparam int SAMPLE_W    = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_HOT_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_DIVIDER  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM_COUNT = 2'd3;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 13'd0;
  localparam logic [HOLD_W-1:0]      HOLD_RESET      = 24'd300000;
  localparam logic [DIVIDER_W-1:0]   DIVIDER_RESET   = 8'd100;
  localparam logic [CONFIRM_W-1:0]   CONFIRM_RESET   = 4'd10;

  localparam logic [CONFIRM_W-1:0]   RUN_MAX = 4'd15;

  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_SCAN = 1'b1;

  localparam logic [1:0] TEMP_OK      = 2'd0;
  localparam logic [1:0] TEMP_HOT     = 2'd1;
  localparam logic [1:0] TEMP_LATCHED = 2'd2;

  localparam logic [1:0] DUTY_FULL    = 2'd0;
  localparam logic [1:0] DUTY_HALF    = 2'd1;
  localparam logic [1:0] DUTY_QUARTER = 2'd2;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'b001,
    MODE_HOT     = 3'b010,
    MODE_LATCHED = 3'b100
  } mode_t;

  typedef struct packed {
    logic [THRESHOLD_W-1:0] hot_threshold_mv;
    logic [HOLD_W-1:0]      hold_ticks;
    logic [DIVIDER_W-1:0]   scan_divider;
    logic [CONFIRM_W-1:0]   confirm_count;
  } cfg_t;

  typedef struct packed {
    mode_t                mode;
    logic [DIVIDER_W-1:0] scan_prescale;
    logic [CONFIRM_W-1:0] normal_confirm;
    logic [CONFIRM_W-1:0] latch_confirm;
  } ctl_t;

  typedef struct packed {
    logic [1:0] temp_state;
    logic [1:0] duty_limit;
    logic       evaluated;
  } res_t;

  typedef struct packed {
    logic [CONFIRM_W-1:0] run;
    logic                 done;
  } run_t;

  function automatic run_t run_step(input logic [CONFIRM_W-1:0] run,
                                    input logic below,
                                    input logic [CONFIRM_W-1:0] confirm);
    run_t r;
    if (below) begin
      r.run = (run == RUN_MAX) ? RUN_MAX : run + 1'b1;
    end else begin
      r.run = '0;
    end
    r.done = (r.run >= confirm);
    if (r.done) begin
      r.run = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/odm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module odm_cfg import odm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hot_threshold_mv <= THRESHOLD_RESET;
      cfg.hold_ticks       <= HOLD_RESET;
      cfg.scan_divider     <= DIVIDER_RESET;
      cfg.confirm_count    <= CONFIRM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HOT_THRESHOLD: cfg.hot_threshold_mv <= cfg_data[THRESHOLD_W-1:0];
        CFG_HOLD_TICKS:    cfg.hold_ticks       <= cfg_data[HOLD_W-1:0];
        CFG_SCAN_DIVIDER:  cfg.scan_divider     <= cfg_data[DIVIDER_W-1:0];
        CFG_CONFIRM_COUNT: cfg.confirm_count    <= cfg_data[CONFIRM_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/odm_step.sv
`timescale 1ns / 1ps
`default_nettype none

module odm_step import odm_pkg::*; #(
  parameter int HOT_TIME_BITS = 24
) (
  input  wire cfg_t                     cfg,
  input  wire ctl_t                     ctl,
  input  wire logic [HOT_TIME_BITS-1:0] hot_time,
  input  wire logic                     action,
  input  wire logic [SAMPLE_W-1:0]      adc_sample,
  output ctl_t                          ctl_next,
  output logic [HOT_TIME_BITS-1:0]      hot_time_next,
  output res_t                          res
);

  localparam int CMP_W = (HOT_TIME_BITS > HOLD_W) ? HOT_TIME_BITS : HOLD_W;

  logic [DIVIDER_W-1:0]   prescale_inc;
  logic [SAMPLE_W+2:0]    sample_x6;
  logic [THRESHOLD_W+2:0] threshold_x5;
  logic                   below;
  logic                   hold_done;
  run_t                   run;

  // The millivolt value is sample * 6 / 5, so comparing sample * 6 against
  // threshold * 5 gives the same answer without a divide.
  assign sample_x6    = ({3'b000, adc_sample} << 2) + ({3'b000, adc_sample} << 1);
  assign threshold_x5 = ({3'b000, cfg.hot_threshold_mv} << 2)
                      + {3'b000, cfg.hot_threshold_mv};
  assign below        = ({1'b0, sample_x6} < threshold_x5);
  assign hold_done    = (CMP_W'(hot_time) >= CMP_W'(cfg.hold_ticks));
  assign prescale_inc = ctl.scan_prescale + 1'b1;

  always_comb begin
    ctl_next      = ctl;
    hot_time_next = hot_time;
    res.evaluated = 1'b0;
    run           = '0;
    if (action == ACTION_TICK) begin
      if (ctl.mode == MODE_HOT) begin
        if (hot_time != {HOT_TIME_BITS{1'b1}}) begin
          hot_time_next = hot_time + HOT_TIME_BITS'(1);
        end
      end else begin
        hot_time_next = '0;
      end
    end else if (ctl.mode != MODE_LATCHED) begin
      ctl_next.scan_prescale = prescale_inc;
      if (prescale_inc >= cfg.scan_divider) begin
        ctl_next.scan_prescale = '0;
        if (ctl.mode == MODE_NORMAL) begin
          res.evaluated           = 1'b1;
          run                     = run_step(ctl.normal_confirm, below, cfg.confirm_count);
          ctl_next.normal_confirm = run.run;
          if (run.done) begin
            ctl_next.mode = MODE_HOT;
          end
        end else if (hold_done) begin
          res.evaluated          = 1'b1;
          run                    = run_step(ctl.latch_confirm, below, cfg.confirm_count);
          ctl_next.latch_confirm = run.run;
          if (run.done) begin
            ctl_next.mode = MODE_LATCHED;
          end
        end
      end
    end

    case (ctl_next.mode)
      MODE_NORMAL: begin
        res.temp_state = TEMP_OK;
        res.duty_limit = DUTY_FULL;
      end
      MODE_HOT: begin
        res.temp_state = TEMP_HOT;
        res.duty_limit = DUTY_HALF;
      end
      MODE_LATCHED: begin
        res.temp_state = TEMP_LATCHED;
        res.duty_limit = DUTY_QUARTER;
      end
      default: begin
        res.temp_state = TEMP_OK;
        res.duty_limit = DUTY_FULL;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/overheat_derate_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// A transaction waits in the input register and its result moves into the result
// register once the output is free. One transaction is accepted every cycle while
// the output is not stalled; the step logic updates all counters in a single pass.
// Synchronous reset returns the state to normal, clears all counters and loads the
// register defaults; no transaction is accepted or presented during reset.

module overheat_derate_monitor import odm_pkg::*; #(
  parameter int HOT_TIME_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   action,
  input  wire logic [SAMPLE_W-1:0]    adc_sample,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  temp_state,
  output logic [1:0]                  duty_limit,
  output logic                        evaluated
);

  cfg_t                     cfg;
  ctl_t                     ctl;
  ctl_t                     ctl_next;
  logic [HOT_TIME_BITS-1:0] hot_time;
  logic [HOT_TIME_BITS-1:0] hot_time_next;
  res_t                     res;

  logic                     hold_valid;
  logic                     hold_action;
  logic [SAMPLE_W-1:0]      hold_sample;
  logic                     advance;

  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  odm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  odm_step #(
    .HOT_TIME_BITS (HOT_TIME_BITS)
  ) u_step (
    .cfg           (cfg),
    .ctl           (ctl),
    .hot_time      (hot_time),
    .action        (hold_action),
    .adc_sample    (hold_sample),
    .ctl_next      (ctl_next),
    .hot_time_next (hot_time_next),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_action <= action;
      hold_sample <= adc_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.mode           <= MODE_NORMAL;
      ctl.scan_prescale  <= '0;
      ctl.normal_confirm <= '0;
      ctl.latch_confirm  <= '0;
      hot_time           <= '0;
    end else if (advance) begin
      ctl      <= ctl_next;
      hot_time <= hot_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      temp_state <= res.temp_state;
      duty_limit <= res.duty_limit;
      evaluated  <= res.evaluated;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/odm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module odm_checker import odm_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] temp_state,
  input wire logic [1:0] duty_limit,
  input wire logic       evaluated
);

  logic seen_latched;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_latched <= 1'b0;
    end else if (out_valid && !out_stall && temp_state == TEMP_LATCHED) begin
      seen_latched <= 1'b1;
    end
  end

  a_duty_follows_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (temp_state == TEMP_OK && duty_limit == DUTY_FULL) ||
                  (temp_state == TEMP_HOT && duty_limit == DUTY_HALF) ||
                  (temp_state == TEMP_LATCHED && duty_limit == DUTY_QUARTER))
    else $error("Duty limit does not match the reported state.");

  a_latched_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && seen_latched) |-> (temp_state == TEMP_LATCHED && !evaluated))
    else $error("A transaction after the latched state changed state or evaluated.");

  a_no_stall_when_output_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("Input stalled although the output side can move.");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(temp_state) &&
                                  $stable(duty_limit) && $stable(evaluated)))
    else $error("A stalled result changed.");

endmodule

bind overheat_derate_monitor odm_checker u_odm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .temp_state (temp_state),
  .duty_limit (duty_limit),
  .evaluated  (evaluated)
);

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import odm_pkg::*;

  localparam int HOT_BITS = 24;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_write  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   action     = ACTION_TICK;
  logic [SAMPLE_W-1:0]    adc_sample = '0;
  logic                   out_stall  = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic [1:0]             temp_state;
  logic [1:0]             duty_limit;
  logic                   evaluated;

  overheat_derate_monitor #(.HOT_TIME_BITS(HOT_BITS)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .adc_sample (adc_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .temp_state (temp_state),
    .duty_limit (duty_limit),
    .evaluated  (evaluated)
  );

  always #5 clk = ~clk;

  // Shadow copy of the monitor's registers and state.
  logic [THRESHOLD_W-1:0] cfg_threshold = THRESHOLD_RESET;
  logic [HOLD_W-1:0]      cfg_hold      = HOLD_RESET;
  logic [DIVIDER_W-1:0]   cfg_divider   = DIVIDER_RESET;
  logic [CONFIRM_W-1:0]   cfg_confirm   = CONFIRM_RESET;

  logic [1:0]             st_mode      = TEMP_OK;
  logic [DIVIDER_W-1:0]   st_prescale  = '0;
  logic [CONFIRM_W-1:0]   st_norm_run  = '0;
  logic [CONFIRM_W-1:0]   st_latch_run = '0;
  logic [HOT_BITS-1:0]    st_hot_ticks = '0;

  res_t predicted_status[$];
  res_t want;

  int idle_pct     = 32;
  int stall_pct    = 32;
  int fail_count   = 0;
  int results_seen = 0;
  int n_ticks      = 0;
  int n_scans      = 0;
  int n_evaluated  = 0;
  int n_writes     = 0;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    fail_count++;
    if (fail_count <= 20) begin
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, results_seen, got, exp_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (predicted_status.size() == 0) begin
        report_mismatch("result with none outstanding", int'(temp_state), 0);
      end else begin
        want = predicted_status.pop_front();
        if (temp_state !== want.temp_state) begin
          report_mismatch("temp_state", int'(temp_state), int'(want.temp_state));
        end
        if (duty_limit !== want.duty_limit) begin
          report_mismatch("duty_limit", int'(duty_limit), int'(want.duty_limit));
        end
        if (evaluated !== want.evaluated) begin
          report_mismatch("evaluated", int'(evaluated), int'(want.evaluated));
        end
      end
    end
  end

  function automatic logic [CONFIRM_W:0] next_run(input logic [CONFIRM_W-1:0] run,
                                                  input logic below);
    logic [CONFIRM_W-1:0] r;
    if (below) begin
      r = (run == 4'd15) ? run : run + 4'd1;
    end else begin
      r = '0;
    end
    if (r >= cfg_confirm) begin
      return {1'b1, {CONFIRM_W{1'b0}}};
    end
    return {1'b0, r};
  endfunction

  function automatic void predict_thermal_step(input logic act,
                                               input logic [SAMPLE_W-1:0] smp);
    res_t                 r;
    int                   mv;
    logic                 below;
    logic                 hit;
    logic [CONFIRM_W:0]   nr;
    hit = 1'b0;
    if (act == ACTION_TICK) begin
      n_ticks++;
      if (st_mode == TEMP_HOT) begin
        if (st_hot_ticks != '1) begin
          st_hot_ticks = st_hot_ticks + 1'b1;
        end
      end else begin
        st_hot_ticks = '0;
      end
    end else begin
      n_scans++;
      if (st_mode != TEMP_LATCHED) begin
        st_prescale = st_prescale + 8'd1;
        if (st_prescale >= cfg_divider) begin
          mv = int'(smp) * 12 / 10;
          below = (mv < int'(cfg_threshold));
          st_prescale = '0;
          if (st_mode == TEMP_OK) begin
            hit = 1'b1;
            nr = next_run(st_norm_run, below);
            st_norm_run = nr[CONFIRM_W-1:0];
            if (nr[CONFIRM_W]) begin
              st_mode = TEMP_HOT;
            end
          end else if (st_hot_ticks >= cfg_hold) begin
            hit = 1'b1;
            nr = next_run(st_latch_run, below);
            st_latch_run = nr[CONFIRM_W-1:0];
            if (nr[CONFIRM_W]) begin
              st_mode = TEMP_LATCHED;
            end
          end
        end
      end
    end
    if (hit) begin
      n_evaluated++;
    end
    r.temp_state = st_mode;
    r.duty_limit = (st_mode == TEMP_HOT) ? DUTY_HALF :
                   (st_mode == TEMP_LATCHED) ? DUTY_QUARTER : DUTY_FULL;
    r.evaluated  = hit;
    predicted_status.push_back(r);
  endfunction

  function automatic logic [SAMPLE_W-1:0] sample_below(input int thr);
    int hi;
    if (thr <= 0) begin
      return SAMPLE_W'($urandom_range(4095));
    end
    hi = (10 * thr - 1) / 12;
    if (hi > 4095) begin
      hi = 4095;
    end
    return SAMPLE_W'($urandom_range(hi, 0));
  endfunction

  function automatic logic [SAMPLE_W-1:0] sample_above(input int thr);
    int lo;
    lo = (10 * thr + 11) / 12;
    if (lo > 4095) begin
      lo = 4095;
    end
    return SAMPLE_W'($urandom_range(4095, lo));
  endfunction

  // Below-threshold runs are kept one short of the confirm count so that the
  // state only moves where a test intends it to.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [CONFIRM_W-1:0] run;
    int                   roll;
    if (st_mode == TEMP_LATCHED) begin
      return SAMPLE_W'($urandom_range(4095));
    end
    run = (st_mode == TEMP_OK) ? st_norm_run : st_latch_run;
    roll = $urandom_range(99);
    if (int'(run) + 1 >= int'(cfg_confirm)) begin
      return sample_above(int'(cfg_threshold));
    end else if (roll < 50) begin
      return sample_below(int'(cfg_threshold));
    end else if (roll < 80) begin
      return sample_above(int'(cfg_threshold));
    end
    return SAMPLE_W'($urandom_range(4095));
  endfunction

  task automatic send_item(input logic act, input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    adc_sample <= smp;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_thermal_step(act, smp);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (predicted_status.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    n_writes++;
    case (idx)
      CFG_HOT_THRESHOLD: cfg_threshold = value[THRESHOLD_W-1:0];
      CFG_HOLD_TICKS:    cfg_hold      = value[HOLD_W-1:0];
      CFG_SCAN_DIVIDER:  cfg_divider   = value[DIVIDER_W-1:0];
      CFG_CONFIRM_COUNT: cfg_confirm   = value[CONFIRM_W-1:0];
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_traffic(input int count, input int tick_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < tick_pct) begin
        send_item(ACTION_TICK, SAMPLE_W'($urandom_range(4095)));
      end else begin
        send_item(ACTION_SCAN, pick_sample());
      end
    end
  endtask

  task automatic test_power_on_defaults();
    send_item(ACTION_TICK, 12'd0);
    send_item(ACTION_SCAN, 12'd0);
    send_item(ACTION_SCAN, 12'd4095);
    send_item(ACTION_TICK, 12'd4095);
    send_item(ACTION_SCAN, 12'd2048);
    send_item(ACTION_SCAN, 12'd1);
  endtask

  task automatic test_scan_evaluation();
    set_reg(CFG_HOT_THRESHOLD, 24'd4914);
    set_reg(CFG_SCAN_DIVIDER, 24'd1);
    set_reg(CFG_CONFIRM_COUNT, 24'd15);
    send_item(ACTION_SCAN, 12'd4095);
    send_item(ACTION_SCAN, 12'd4094);
    send_item(ACTION_SCAN, 12'd0);
    send_item(ACTION_TICK, 12'd0);
    send_item(ACTION_SCAN, 12'd4095);
    set_reg(CFG_SCAN_DIVIDER, 24'd0);
    send_item(ACTION_SCAN, 12'd2048);
    send_item(ACTION_SCAN, 12'd2047);
    send_item(ACTION_SCAN, 12'hAAA);
    send_item(ACTION_SCAN, 12'h555);
  endtask

  task automatic test_divider_limits();
    set_reg(CFG_SCAN_DIVIDER, 24'd255);
    for (int i = 0; i < 40; i++) begin
      send_item(ACTION_SCAN, pick_sample());
    end
    set_reg(CFG_SCAN_DIVIDER, 24'd3);
    for (int i = 0; i < 4; i++) begin
      send_item(ACTION_SCAN, pick_sample());
    end
  endtask

  task automatic test_normal_traffic();
    for (int b = 0; b < 4; b++) begin
      set_reg(CFG_HOT_THRESHOLD, 24'($urandom_range(4914, 1)));
      set_reg(CFG_SCAN_DIVIDER, 24'($urandom_range(5)));
      set_reg(CFG_CONFIRM_COUNT, 24'($urandom_range(15, 1)));
      if (b == 2) begin
        idle_pct  = 0;
        stall_pct = 0;
        random_traffic(60, 25);
        idle_pct  = 32;
        stall_pct = 32;
      end else begin
        random_traffic(50, 25);
      end
    end
  endtask

  task automatic test_enter_hot();
    set_reg(CFG_HOT_THRESHOLD, 24'd0);
    set_reg(CFG_CONFIRM_COUNT, 24'd0);
    set_reg(CFG_SCAN_DIVIDER, 24'd1);
    send_item(ACTION_TICK, 12'd0);
    send_item(ACTION_SCAN, 12'd4095);
    set_reg(CFG_CONFIRM_COUNT, 24'd15);
    send_item(ACTION_TICK, 12'd0);
    send_item(ACTION_TICK, 12'd4095);
    send_item(ACTION_TICK, 12'd0);
  endtask

  task automatic test_hold_time();
    set_reg(CFG_HOLD_TICKS, 24'hFFFFFF);
    set_reg(CFG_HOT_THRESHOLD, 24'd4914);
    send_item(ACTION_SCAN, 12'd0);
    send_item(ACTION_SCAN, 12'd0);
    send_item(ACTION_TICK, 12'd0);
    send_item(ACTION_SCAN, 12'd4095);
    set_reg(CFG_HOLD_TICKS, 24'd0);
    send_item(ACTION_SCAN, 12'd0);
    send_item(ACTION_SCAN, 12'd4095);
    send_item(ACTION_TICK, 12'd0);
    send_item(ACTION_SCAN, 12'd2048);
  endtask

  task automatic test_hot_traffic();
    for (int b = 0; b < 4; b++) begin
      set_reg(CFG_HOT_THRESHOLD, 24'($urandom_range(4914, 1)));
      set_reg(CFG_HOLD_TICKS, 24'($urandom_range(80)));
      set_reg(CFG_SCAN_DIVIDER, 24'($urandom_range(2)));
      set_reg(CFG_CONFIRM_COUNT, 24'($urandom_range(15, 2)));
      random_traffic(40, 35);
    end
  endtask

  task automatic test_latch();
    set_reg(CFG_HOT_THRESHOLD, 24'h1FFF);
    set_reg(CFG_CONFIRM_COUNT, 24'd15);
    set_reg(CFG_HOLD_TICKS, 24'd0);
    set_reg(CFG_SCAN_DIVIDER, 24'd1);
    for (int i = 0; i < 16; i++) begin
      send_item(ACTION_SCAN, SAMPLE_W'($urandom_range(4095)));
    end
  endtask

  task automatic test_latched_traffic();
    set_reg(CFG_SCAN_DIVIDER, 24'd0);
    set_reg(CFG_CONFIRM_COUNT, 24'd1);
    random_traffic(20, 40);
    set_reg(CFG_HOT_THRESHOLD, 24'($urandom_range(8191)));
    set_reg(CFG_HOLD_TICKS, 24'($urandom_range(24'hFFFFFF)));
    random_traffic(20, 40);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_on_defaults();
    test_scan_evaluation();
    test_divider_limits();
    test_normal_traffic();
    test_enter_hot();
    test_hold_time();
    test_hot_traffic();
    test_latch();
    test_latched_traffic();
    wait_idle();
    repeat (5) @(posedge clk);
    $display("Exercised %0d ticks and %0d scans (%0d evaluated) across %0d register writes.",
             n_ticks, n_scans, n_evaluated, n_writes);
    $display("The monitor went from normal through hot to latched; %0d results checked.",
             results_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run did not complete in time.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
